[sv/base64_stream_encoder_assert.svh]
// Assertion macros for the base64 stream encoder.
// Expects clk and rst_n in scope at the point of use.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// same-cycle implication
`define B64SE_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64se assertion failed");

// next-cycle implication
`define B64SE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64se assertion failed");

`endif

[sv/b64se_pkg.sv]
// Shared types, constants and character mapping for the base64 stream encoder.
// No dependencies.
package b64se_pkg;

  typedef logic [6:0] char_t;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       is_final;
  } in_beat_t;

  typedef struct packed {
    char_t out_char;
    logic  run_end;
  } out_beat_t;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  typedef struct packed {
    char_t [3:0] chars;
    logic  [1:0] last_idx;
  } job_t;

  localparam char_t CHAR_PAD   = 7'h3D;
  localparam char_t CHAR_PLUS  = 7'h2B;
  localparam char_t CHAR_COMMA = 7'h2C;
  localparam char_t CHAR_UP_A  = 7'h41;
  localparam char_t CHAR_LO_A  = 7'h61;
  localparam char_t CHAR_ZERO  = 7'h30;

  function automatic char_t b64_char(input logic [5:0] v);
    char_t c;
    if (v < 6'd26) begin
      c = CHAR_UP_A + {1'b0, v};
    end else if (v < 6'd52) begin
      c = CHAR_LO_A + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      c = CHAR_ZERO + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_COMMA;
    end
    return c;
  endfunction

endpackage

[sv/b64se_core.sv]
// Group phase state and character formation for one source beat.
// Depends on b64se_pkg and base64_stream_encoder_assert.svh.
`include "base64_stream_encoder_assert.svh"

module b64se_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  b64se_pkg::in_beat_t in_data,
  input  logic               job_ready,
  output logic               job_valid,
  output b64se_pkg::job_t    job
);

  b64se_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]        carry_r, carry_nxt;
  logic              job_valid_r, job_valid_nxt;
  b64se_pkg::job_t   job_r, job_nxt;
  logic              accept;
  logic [7:0]        b;

  assign in_stall  = job_valid_r && !job_ready;
  assign accept    = in_valid && !in_stall;
  assign job_valid = job_valid_r;
  assign job       = job_r;
  assign b         = in_data.src_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= b64se_pkg::PH_0;
      carry_r     <= 4'd0;
      job_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      carry_r     <= carry_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_comb begin
    phase_nxt     = phase_r;
    carry_nxt     = carry_r;
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    if (job_ready) begin
      job_valid_nxt = 1'b0;
    end
    if (accept) begin
      job_valid_nxt    = 1'b1;
      job_nxt.chars[1] = b64se_pkg::CHAR_PAD;
      job_nxt.chars[2] = b64se_pkg::CHAR_PAD;
      job_nxt.chars[3] = b64se_pkg::CHAR_PAD;
      case (phase_r)
        b64se_pkg::PH_1: begin
          job_nxt.chars[0] = b64se_pkg::b64_char({carry_r[1:0], b[7:4]});
          if (in_data.is_final) begin
            job_nxt.chars[1] = b64se_pkg::b64_char({b[3:0], 2'b00});
            job_nxt.last_idx = 2'd2;
          end else begin
            job_nxt.last_idx = 2'd0;
            carry_nxt        = b[3:0];
            phase_nxt        = b64se_pkg::PH_2;
          end
        end
        b64se_pkg::PH_2: begin
          job_nxt.chars[0] = b64se_pkg::b64_char({carry_r, b[7:6]});
          job_nxt.chars[1] = b64se_pkg::b64_char(b[5:0]);
          job_nxt.last_idx = 2'd1;
          carry_nxt        = 4'd0;
          phase_nxt        = b64se_pkg::PH_0;
        end
        default: begin
          job_nxt.chars[0] = b64se_pkg::b64_char(b[7:2]);
          if (in_data.is_final) begin
            job_nxt.chars[1] = b64se_pkg::b64_char({b[1:0], 4'b0000});
            job_nxt.last_idx = 2'd3;
          end else begin
            job_nxt.last_idx = 2'd0;
            carry_nxt        = {2'b00, b[1:0]};
            phase_nxt        = b64se_pkg::PH_1;
          end
        end
      endcase
      if (in_data.is_final) begin
        carry_nxt = 4'd0;
        phase_nxt = b64se_pkg::PH_0;
      end
    end
  end

  `B64SE_ASSERT_NXT(a_final_clears,
    accept && in_data.is_final, phase_r == b64se_pkg::PH_0 && carry_r == 4'd0)
  `B64SE_ASSERT_NXT(a_ph0_to_ph1,
    accept && !in_data.is_final && phase_r == b64se_pkg::PH_0, phase_r == b64se_pkg::PH_1)
  `B64SE_ASSERT_NXT(a_job_holds,
    job_valid_r && !job_ready && !accept, job_valid_r && $stable(job_r))

endmodule

[sv/b64se_emit.sv]
// Character serialiser: holds one job and sends its characters one beat at a time.
// Depends on b64se_pkg and base64_stream_encoder_assert.svh.
`include "base64_stream_encoder_assert.svh"

module b64se_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  b64se_pkg::job_t     job,
  output logic                out_valid,
  input  logic                out_stall,
  output b64se_pkg::out_beat_t out_data
);

  logic                 busy_r, busy_nxt;
  logic [1:0]           idx_r, idx_nxt;
  b64se_pkg::job_t      hold_r, hold_nxt;
  logic                 at_last;
  logic                 take;
  logic                 load;

  assign at_last   = idx_r == hold_r.last_idx;
  assign take      = busy_r && !out_stall && at_last;
  assign job_ready = !busy_r || take;
  assign load      = job_valid && job_ready;

  assign out_valid         = busy_r;
  assign out_data.out_char = hold_r.chars[idx_r];
  assign out_data.run_end  = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    hold_nxt = hold_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
      hold_nxt = job;
    end else if (take) begin
      busy_nxt = 1'b0;
      idx_nxt  = 2'd0;
    end else if (busy_r && !out_stall) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  `B64SE_ASSERT_NOW(a_idx_in_range, busy_r, idx_r <= hold_r.last_idx)
  `B64SE_ASSERT_NXT(a_stall_holds, busy_r && out_stall, busy_r && $stable(idx_r))
  `B64SE_ASSERT_NXT(a_drain_idle, take && !job_valid, !busy_r)

endmodule

[sv/base64_stream_encoder.sv]
// Streaming base64 encoder, alphabet A-Z a-z 0-9 '+' ',' with '=' padding: one
// source byte in per beat, one ASCII character out per beat. A byte yields one
// character (phase 0 or 1), two (phase 2), or the flushed and padded rest of the
// quartet when flagged final; run_end marks the last character of each byte.
// The output port sends one character per cycle unless out_stall holds it; a
// new byte is taken while earlier characters are still going out. A byte passes
// through the core's job register and then the emitter's hold register before
// its first character goes out. Depends on b64se_pkg, b64se_core and b64se_emit.
module base64_stream_encoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  b64se_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output b64se_pkg::out_beat_t out_data
);

  logic            job_valid;
  logic            job_ready;
  b64se_pkg::job_t job;

  b64se_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_ready (job_ready),
    .job_valid (job_valid),
    .job       (job)
  );

  b64se_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
